// ----- hdl/lswr_pkg.sv -----
// ============================================================================
// lswr_pkg: shared types and constants for the reversible LIFO stack
// Holds the stack geometry, request codes, item types and ring helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lswr_pkg;

  // Stack geometry.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  localparam logic [IDX_W:0]   DEPTH_IX  = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Request codes.
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_PEEK    = 2'd2;
  localparam logic [1:0] REQ_REVERSE = 2'd3;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     empty_flag;
    logic                     full_flag;
  } out_item_t;

  // Decoded command as it travels through the queue.
  typedef struct packed {
    logic                     is_push;
    logic                     is_read;
    logic                     is_pop;
    logic                     is_rev;
    logic signed [WORD_W-1:0] word;
  } cmd_t;

  // Ring position that lies off steps from the bottom, in the growth
  // direction. Both inputs are below DEPTH, so one correction suffices.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] b,
                                                input logic [IDX_W-1:0] off,
                                                input logic             down);
    logic [IDX_W:0] sum;
    logic [IDX_W:0] pos;
    sum = {1'b0, b} + {1'b0, off};
    if (down) begin
      if (b >= off) begin
        pos = {1'b0, b} - {1'b0, off};
      end else begin
        pos = {1'b0, b} + DEPTH_IX - {1'b0, off};
      end
    end else begin
      pos = (sum >= DEPTH_IX) ? (sum - DEPTH_IX) : sum;
    end
    return pos[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lswr_ram.sv -----
// ============================================================================
// lswr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lswr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/lswr_front.sv -----
// ============================================================================
// lswr_front: request intake and decode
// Accepts requests while the command queue has room and decodes them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lswr_front (
  input  wire logic             start,
  input  wire lswr_pkg::in_item_t request,
  input  wire logic             q_full,
  output logic                  busy,
  output logic                  q_wr,
  output lswr_pkg::cmd_t        q_cmd
);

  assign busy = q_full;
  assign q_wr = start && !q_full;

  always_comb begin
    q_cmd         = '0;
    q_cmd.word    = request.push_value;
    case (request.req_type)
      lswr_pkg::REQ_PUSH: begin
        q_cmd.is_push = 1'b1;
      end
      lswr_pkg::REQ_POP: begin
        q_cmd.is_read = 1'b1;
        q_cmd.is_pop  = 1'b1;
      end
      lswr_pkg::REQ_PEEK: begin
        q_cmd.is_read = 1'b1;
      end
      lswr_pkg::REQ_REVERSE: begin
        q_cmd.is_rev = 1'b1;
      end
      default: begin
        q_cmd.is_rev = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/lswr_queue.sv -----
// ============================================================================
// lswr_queue: short command queue
// Small register FIFO that decouples request intake from execution.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lswr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire lswr_pkg::cmd_t wr_cmd,
  output logic                full,
  input  wire logic           rd,
  output logic                valid,
  output lswr_pkg::cmd_t      rd_cmd
);

  lswr_pkg::cmd_t               slots [lswr_pkg::QUEUE_DEPTH];
  logic [lswr_pkg::QP_W-1:0]    wr_ptr;
  logic [lswr_pkg::QP_W-1:0]    rd_ptr;
  logic [lswr_pkg::QC_W-1:0]    count;
  logic                         do_wr;
  logic                         do_rd;

  localparam logic [lswr_pkg::QP_W-1:0] LAST_PTR =
    lswr_pkg::QP_W'(lswr_pkg::QUEUE_DEPTH - 1);
  localparam logic [lswr_pkg::QC_W-1:0] FULL_CNT =
    lswr_pkg::QC_W'(lswr_pkg::QUEUE_DEPTH);

  assign full   = (count == FULL_CNT);
  assign valid  = (count != '0);
  assign rd_cmd = slots[rd_ptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lswr_back.sv -----
// ============================================================================
// lswr_back: stack execution engine
// Runs queued commands against the ring store and registers each result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lswr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire lswr_pkg::cmd_t q_cmd,
  output logic                q_rd,
  output logic                strobe,
  output lswr_pkg::out_item_t result
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                             state;
  logic                             state_next;
  logic [lswr_pkg::CNT_W-1:0]       fill_count;
  logic [lswr_pkg::CNT_W-1:0]       fill_count_next;
  logic [lswr_pkg::IDX_W-1:0]       bottom_index;
  logic [lswr_pkg::IDX_W-1:0]       bottom_index_next;
  logic                             grow_down;
  logic                             grow_down_next;
  logic                             strobe_next;
  lswr_pkg::out_item_t              result_next;

  logic [lswr_pkg::CNT_W-1:0]       fill_less;
  logic [lswr_pkg::IDX_W-1:0]       push_pos;
  logic [lswr_pkg::IDX_W-1:0]       top_pos;
  logic                             ram_we;
  logic [lswr_pkg::WORD_W-1:0]      ram_rdata;

  assign fill_less = fill_count - lswr_pkg::CNT_W'(1);
  assign push_pos  = lswr_pkg::ring_pos(bottom_index,
                                        fill_count[lswr_pkg::IDX_W-1:0], grow_down);
  assign top_pos   = lswr_pkg::ring_pos(bottom_index,
                                        fill_less[lswr_pkg::IDX_W-1:0], grow_down);

  lswr_ram #(
    .WIDTH (lswr_pkg::WORD_W),
    .DEPTH (lswr_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (push_pos),
    .wdata (q_cmd.word),
    .raddr (top_pos),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next        = state;
    fill_count_next   = fill_count;
    bottom_index_next = bottom_index;
    grow_down_next    = grow_down;
    strobe_next       = 1'b0;
    result_next       = '0;
    q_rd              = 1'b0;
    ram_we            = 1'b0;
    case (state)
      ST_RUN: begin
        if (q_valid) begin
          q_rd = 1'b1;
          if (q_cmd.is_push) begin
            strobe_next = 1'b1;
            if (fill_count >= lswr_pkg::DEPTH_CNT) begin
              result_next.full_flag = 1'b1;
            end else begin
              ram_we          = 1'b1;
              fill_count_next = fill_count + 1'b1;
            end
          end else if (q_cmd.is_read) begin
            if (fill_count == '0) begin
              strobe_next            = 1'b1;
              result_next.read_value = lswr_pkg::EMPTY_WORD;
              result_next.empty_flag = 1'b1;
            end else begin
              // The top word comes out of the store on the next cycle.
              state_next = ST_READ;
              if (q_cmd.is_pop) begin
                fill_count_next = fill_less;
              end
            end
          end else begin
            strobe_next = 1'b1;
            if (fill_count >= lswr_pkg::CNT_W'(2)) begin
              bottom_index_next = top_pos;
              grow_down_next    = !grow_down;
            end
          end
        end
      end
      ST_READ: begin
        strobe_next            = 1'b1;
        result_next.read_value = $signed(ram_rdata);
        state_next             = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      fill_count   <= '0;
      bottom_index <= '0;
      grow_down    <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      fill_count   <= fill_count_next;
      bottom_index <= bottom_index_next;
      grow_down    <= grow_down_next;
      strobe       <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

// ----- hdl/lifo_stack_with_reverse_top.sv -----
// ============================================================================
// lifo_stack_with_reverse_top: bounded LIFO stack with one-step reverse
// Push, pop, peek and whole-stack reverse on signed 32-bit words.
// ============================================================================
// A request item is taken at a clock edge where start is high and busy is
// low; every item produces exactly one result item, shown on result for a
// single cycle while strobe is high, in request order. The receiver cannot
// stall, so results must be taken as they appear. A push, a reverse, a push
// onto a full stack and a pop or peek of an empty stack each go through the
// command queue and then straight into the registered result when the engine
// is free. A pop or peek that returns a word also passes through the read
// state of the engine, because the stack store is a RAM with a registered
// read port. A two-entry command queue sits between intake and execution,
// so busy rises only when that queue is full; sustained rate is one item per
// cycle for pushes and reverses, while a pop or peek that hits a word keeps
// the next item waiting in the queue during that read state. A pop or peek
// of an empty stack returns -1 with empty_flag set; a push onto a full stack
// is dropped with full_flag set. Reverse moves the bottom pointer to the old
// top and flips the growth direction inside the ring, so no data moves. After
// reset the stack is empty; the store needs no clearing pass, since only
// pushed entries are ever read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_reverse_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire lswr_pkg::in_item_t request,
  output logic                    strobe,
  output lswr_pkg::out_item_t     result
);

  logic           q_full;
  logic           q_wr;
  lswr_pkg::cmd_t q_wr_cmd;
  logic           q_rd;
  logic           q_valid;
  lswr_pkg::cmd_t q_rd_cmd;

  // Intake: decode the request and push it into the queue.
  lswr_front u_front (
    .start   (start),
    .request (request),
    .q_full  (q_full),
    .busy    (busy),
    .q_wr    (q_wr),
    .q_cmd   (q_wr_cmd)
  );

  // Queue that lets intake and execution run independently.
  lswr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd     (q_rd),
    .valid  (q_valid),
    .rd_cmd (q_rd_cmd)
  );

  // Execution: stack pointers, ring store and the result register.
  lswr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_rd_cmd),
    .q_rd    (q_rd),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

`default_nettype wire

// ----- hdl/lswr_checker.sv -----
// ============================================================================
// lswr_checker: port-level checks for the reversible LIFO stack
// Watches the top-level ports and flags results that cannot be right.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lswr_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire lswr_pkg::in_item_t  request,
  input wire logic                strobe,
  input wire lswr_pkg::out_item_t result
);

  // No result may follow a reset cycle.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result strobe right after reset");

  // A result never reports both error flags.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.empty_flag && result.full_flag))
    else $error("empty and full flags both set");

  // An empty read always carries the all-ones word.
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.empty_flag) |-> (result.read_value == lswr_pkg::EMPTY_WORD))
    else $error("empty read without the -1 word");

  // A dropped push returns a zero word.
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.full_flag) |-> (result.read_value == '0))
    else $error("dropped push with a nonzero word");

  // A pop taken right after reset must come back with the empty flag set.
  a_pop_after_reset: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && start && !busy && (request.req_type == lswr_pkg::REQ_POP))
      |-> ##2 (strobe && result.empty_flag))
    else $error("pop after reset did not report an empty stack");

endmodule

bind lifo_stack_with_reverse_top lswr_checker u_lswr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);

`default_nettype wire

// ----- sim/tb_lifo_stack_with_reverse_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_lifo_stack_with_reverse_top: self-checking bench for the reversible stack
// Sends push, pop, peek and reverse requests through the start/busy handshake
// and predicts every result item with a ring model of its own. Each strobed
// result is checked field by field, in request order, against that model.
// ============================================================================

module tb_lifo_stack_with_reverse_top;

  // Clock, reset and the block's ports.
  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  lswr_pkg::in_item_t  request;
  logic                strobe;
  lswr_pkg::out_item_t result;

  lifo_stack_with_reverse_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  // Shadow copy of the stack. The words sit in a ring of DEPTH slots;
  // base_slot is the bottom word and grows_down tells which way the stack
  // extends from it, so a reverse only moves the base and flips the way.
  logic signed [lswr_pkg::WORD_W-1:0] ring_word [lswr_pkg::DEPTH];
  logic [lswr_pkg::CNT_W-1:0]         held_count;
  logic [lswr_pkg::IDX_W-1:0]         base_slot;
  logic                               grows_down;

  // Result items still owed by the block, oldest first.
  lswr_pkg::out_item_t owed_results [$];

  // When set, the sender never pauses between items.
  bit steady_run;

  int error_count;
  int n_push, n_pop, n_peek, n_rev;
  int n_empty_reads, n_dropped_pushes, n_flips, n_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slot that lies off places above the bottom word, measured in the
  // current growth direction, wrapped around the ring.
  function automatic logic [lswr_pkg::IDX_W-1:0] slot_at(input int off);
    int pos;
    if (grows_down) begin
      pos = (int'(base_slot) + lswr_pkg::DEPTH - (off % lswr_pkg::DEPTH)) % lswr_pkg::DEPTH;
    end else begin
      pos = (int'(base_slot) + off) % lswr_pkg::DEPTH;
    end
    return lswr_pkg::IDX_W'(pos);
  endfunction

  // Applies one accepted request to the shadow stack and returns the result
  // item that the block has to produce for it.
  function automatic lswr_pkg::out_item_t stack_reply(input lswr_pkg::in_item_t item);
    lswr_pkg::out_item_t reply;
    reply = '0;
    case (item.req_type)
      lswr_pkg::REQ_PUSH: begin
        n_push++;
        if (held_count >= lswr_pkg::DEPTH_CNT) begin
          // A push onto a full stack is dropped and flagged.
          reply.full_flag = 1'b1;
          n_dropped_pushes++;
        end else begin
          ring_word[slot_at(int'(held_count))] = item.push_value;
          held_count++;
        end
      end
      lswr_pkg::REQ_POP, lswr_pkg::REQ_PEEK: begin
        if (item.req_type == lswr_pkg::REQ_POP) n_pop++;
        else                                    n_peek++;
        if (held_count == '0) begin
          // Reading an empty stack gives the all-ones word and the flag.
          reply.read_value = lswr_pkg::EMPTY_WORD;
          reply.empty_flag = 1'b1;
          n_empty_reads++;
        end else begin
          reply.read_value = ring_word[slot_at(int'(held_count) - 1)];
          if (item.req_type == lswr_pkg::REQ_POP) held_count--;
        end
      end
      default: begin
        n_rev++;
        // With fewer than two words the order is already its own reverse.
        if (held_count >= 2) begin
          base_slot  = slot_at(int'(held_count) - 1);
          grows_down = ~grows_down;
          n_flips++;
        end
      end
    endcase
    return reply;
  endfunction

  function automatic lswr_pkg::in_item_t make_item(
      input logic [1:0]                       op,
      input logic signed [lswr_pkg::WORD_W-1:0] value);
    lswr_pkg::in_item_t item;
    item.req_type   = op;
    item.push_value = value;
    return item;
  endfunction

  // Presents one item, holds it until the block takes it, then records the
  // result it owes. Afterwards the sender may pause with start low; start
  // stays high when it does not, so back-to-back items need no extra edge.
  task automatic send_item(input lswr_pkg::in_item_t item);
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    owed_results.push_back(stack_reply(item));
    if (!steady_run && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Every strobe carries one result item. It must match the oldest owed
  // item; a strobe with nothing owed is an error on its own.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result item: read_value %0d empty_flag %0b full_flag %0b",
               result.read_value, result.empty_flag, result.full_flag);
        error_count++;
      end else begin
        lswr_pkg::out_item_t want;
        want = owed_results.pop_front();
        n_checked++;
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
          error_count++;
        end
        if (result.empty_flag !== want.empty_flag) begin
          $error("empty_flag: expected %0b, got %0b", want.empty_flag, result.empty_flag);
          error_count++;
        end
        if (result.full_flag !== want.full_flag) begin
          $error("full_flag: expected %0b, got %0b", want.full_flag, result.full_flag);
          error_count++;
        end
      end
    end
  end

  // Reads and a reverse on a freshly reset, empty stack.
  task automatic test_empty_stack();
    send_item(make_item(lswr_pkg::REQ_POP, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_PEEK, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_REVERSE, 32'sd0));
  endtask

  // Extreme words, a reverse of a single word, a reverse of several words,
  // and draining down past empty.
  task automatic test_extremes_and_reverse();
    send_item(make_item(lswr_pkg::REQ_PUSH, 32'sh8000_0000));
    send_item(make_item(lswr_pkg::REQ_REVERSE, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_PEEK, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_PUSH, 32'sh7FFF_FFFF));
    send_item(make_item(lswr_pkg::REQ_PUSH, -32'sd1));
    send_item(make_item(lswr_pkg::REQ_PUSH, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_REVERSE, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_PEEK, 32'sd0));
    repeat (5) send_item(make_item(lswr_pkg::REQ_POP, 32'sd0));
  endtask

  // Fills the stack to its limit with alternating bit patterns, checks that
  // further pushes are dropped, and reads back across a reverse.
  task automatic test_full_stack();
    for (int k = 0; k < lswr_pkg::DEPTH; k++) begin
      send_item(make_item(lswr_pkg::REQ_PUSH, k[0] ? 32'shAAAA_AAAA : 32'sh5555_5555));
    end
    send_item(make_item(lswr_pkg::REQ_PUSH, 32'sh1234_5678));
    send_item(make_item(lswr_pkg::REQ_REVERSE, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_PUSH, -32'sd1));
    send_item(make_item(lswr_pkg::REQ_PEEK, 32'sd0));
    send_item(make_item(lswr_pkg::REQ_POP, 32'sd0));
  endtask

  // Random traffic in bursts. Each burst leans toward filling, draining or
  // an even mix, so the stack keeps running into both ends and the bottom
  // wanders all around the ring through frequent reverses. A stretch in the
  // middle runs with no pauses at all.
  task automatic test_random_traffic(input int target);
    int                                 sent;
    int                                 burst;
    int                                 lean;
    int                                 roll;
    int                                 push_cut;
    int                                 pop_cut;
    logic [1:0]                         op;
    logic signed [lswr_pkg::WORD_W-1:0] value;
    sent = 0;
    while (sent < target) begin
      lean  = $urandom_range(2);
      burst = $urandom_range(16, 60);
      steady_run = (sent >= target / 3) && (sent < target / 2);
      // Cut points for push and pop; what is left splits into peek and reverse.
      push_cut = (lean == 0) ? 60 : (lean == 1) ? 15 : 35;
      pop_cut  = (lean == 0) ? 75 : (lean == 1) ? 65 : 65;
      for (int k = 0; k < burst && sent < target; k++) begin
        roll = $urandom_range(99);
        if (roll < push_cut)     op = lswr_pkg::REQ_PUSH;
        else if (roll < pop_cut) op = lswr_pkg::REQ_POP;
        else if (roll < 85)      op = lswr_pkg::REQ_PEEK;
        else                     op = lswr_pkg::REQ_REVERSE;
        case ($urandom_range(11))
          0:       value = 32'sh8000_0000;
          1:       value = 32'sh7FFF_FFFF;
          2:       value = -32'sd1;
          default: value = $urandom();
        endcase
        send_item(make_item(op, value));
        sent++;
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    int guard;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    held_count = '0;
    base_slot  = '0;
    grows_down = 1'b0;
    steady_run = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_extremes_and_reverse();
    test_full_stack();
    test_random_traffic(910);
    start <= 1'b0;

    // Let the pipeline drain, then watch a little longer for stray strobes.
    guard = 0;
    while (owed_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    while (owed_results.size() != 0) begin
      lswr_pkg::out_item_t lost;
      lost = owed_results.pop_front();
      $error("missing result item: read_value %0d empty_flag %0b full_flag %0b",
             lost.read_value, lost.empty_flag, lost.full_flag);
      error_count++;
    end

    $display("Covered %0d pushes, %0d pops, %0d peeks and %0d reverses (%0d flips).",
             n_push, n_pop, n_peek, n_rev, n_flips);
    $display("Saw %0d empty reads and %0d dropped pushes; %0d result items checked.",
             n_empty_reads, n_dropped_pushes, n_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs; a clean run needs far less time.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
